/* src/fsed_pkg.sv */
// Shared types and constants for the error diffusion buffer.
// No dependencies; used by fsed_ram and fs_error_diffusion_buffer.
package fsed_pkg;

  localparam int MAX_LINE  = 1024;
  localparam int COL_W     = $clog2(MAX_LINE);
  localparam int ADDR_W    = COL_W + 1;
  localparam int RAM_DEPTH = 2 * MAX_LINE;
  localparam int ACC_W     = 13;
  localparam int ERR_W     = 8;
  localparam int LW_W      = 11;

  typedef logic [COL_W-1:0]        col_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [ACC_W-1:0]        acc_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [LW_W-1:0]         lw_t;

  localparam col_t COL_LAST = col_t'(MAX_LINE - 1);
  localparam lw_t  LW_MAX   = lw_t'(MAX_LINE);

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_MEM,
    SRC_TAIL,
    SRC_ROW0
  } src_t;

  typedef struct packed {
    err_t err;
    col_t col;
    logic bank;
    logic wrap;
    src_t src;
  } s1_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    acc_t  data;
  } wr_req_t;

endpackage

/* src/fsed_ram.sv */
// Two-bank line store, one write and one registered read per cycle.
// Depends on fsed_pkg for widths and the write request struct.
module fsed_ram (
  input  logic             clk,
  input  fsed_pkg::wr_req_t wr,
  input  logic             rd_en,
  input  fsed_pkg::addr_t  rd_addr,
  output fsed_pkg::acc_t   rd_data
);

  fsed_pkg::acc_t mem [fsed_pkg::RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // forward a write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

/* src/fs_error_diffusion_buffer.sv */
// An accepted error passes through the s1 register and then the result register, which holds its correction.
// Throughput: one error per cycle while err_stall is low; the line store does one read and one write per cycle.
// Reset and a line width write clear position, bank and the first-line flag at once;
// the line store itself is never swept, first-line reads are forced to zero.
// Top level of the error diffusion buffer.
// Depends on fsed_pkg and fsed_ram.
module fs_error_diffusion_buffer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  fsed_pkg::lw_t        cfg_data,
  input  logic                 err_valid,
  output logic                 err_stall,
  input  fsed_pkg::err_t       err_in,
  output logic                 corr_valid,
  input  logic                 corr_stall,
  output fsed_pkg::err_t       next_correction
);

  fsed_pkg::col_t    eff_last;
  fsed_pkg::col_t    eff_last_next;
  fsed_pkg::col_t    col;
  fsed_pkg::col_t    col_inc;
  logic              bank;
  logic              first_line;
  logic              wrap_now;
  logic              tail_hit;
  logic              accept;
  logic              cfg_write;
  logic              retire;
  logic              s1_adv;
  logic              s1_valid;
  fsed_pkg::s1_t     s1;
  fsed_pkg::src_t    src_next;
  logic              res_valid;
  fsed_pkg::err_t    res;
  fsed_pkg::acc_t    q;
  fsed_pkg::acc_t    p0;
  fsed_pkg::acc_t    row0;
  fsed_pkg::acc_t    tail;
  fsed_pkg::acc_t    rd_data;
  fsed_pkg::acc_t    e1;
  fsed_pkg::acc_t    e3;
  fsed_pkg::acc_t    e5;
  fsed_pkg::acc_t    e7;
  fsed_pkg::acc_t    fin_prev;
  fsed_pkg::acc_t    q_next;
  fsed_pkg::acc_t    row0_val;
  fsed_pkg::acc_t    cur_val;
  fsed_pkg::acc_t    sum;
  fsed_pkg::wr_req_t wr;

  assign cfg_ready       = !s1_valid;
  assign cfg_write       = cfg_valid && cfg_ready;
  assign s1_adv          = !res_valid || !corr_stall;
  // hold requests while a width write is pending or the first stage cannot advance
  assign err_stall       = cfg_valid || (s1_valid && !s1_adv);
  assign accept          = err_valid && !err_stall;
  assign retire          = s1_valid && s1_adv;
  assign corr_valid      = res_valid;
  assign next_correction = res;

  always_comb begin
    if (cfg_data == '0) begin
      eff_last_next = '0;
    end else if (cfg_data > fsed_pkg::LW_MAX) begin
      eff_last_next = fsed_pkg::COL_LAST;
    end else begin
      eff_last_next = fsed_pkg::col_t'(cfg_data - fsed_pkg::lw_t'(1));
    end
  end

  assign col_inc  = col + fsed_pkg::col_t'(1);
  assign wrap_now = (col == eff_last);
  assign tail_hit = (col_inc == eff_last);

  always_comb begin
    if (wrap_now) begin
      src_next = fsed_pkg::SRC_ROW0;
    end else if (first_line) begin
      src_next = fsed_pkg::SRC_ZERO;
    end else if (tail_hit) begin
      src_next = fsed_pkg::SRC_TAIL;
    end else begin
      src_next = fsed_pkg::SRC_MEM;
    end
  end

  // position, bank and line store addressing advance on each accepted request; reset and a width write clear them
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_last   <= fsed_pkg::COL_LAST;
      col        <= '0;
      bank       <= 1'b0;
      first_line <= 1'b1;
    end else if (cfg_write) begin
      eff_last   <= eff_last_next;
      col        <= '0;
      bank       <= 1'b0;
      first_line <= 1'b1;
    end else if (accept) begin
      if (wrap_now) begin
        col        <= '0;
        bank       <= !bank;
        first_line <= 1'b0;
      end else begin
        col <= col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.err  <= err_in;
      s1.col  <= col;
      s1.bank <= bank;
      s1.wrap <= wrap_now;
      s1.src  <= src_next;
    end
  end

  fsed_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (accept),
    .rd_addr ({bank, col_inc}),
    .rd_data (rd_data)
  );

  assign e1       = {{(fsed_pkg::ACC_W - fsed_pkg::ERR_W){s1.err[fsed_pkg::ERR_W-1]}}, s1.err};
  assign e3       = (e1 << 1) + e1;
  assign e5       = (e1 << 2) + e1;
  assign e7       = (e1 << 3) - e1;
  assign fin_prev = q + e3;
  assign q_next   = (s1.col == '0) ? e5 : (p0 + e5);

  always_comb begin
    if (s1.col == '0) begin
      row0_val = e5;
    end else if (s1.col == fsed_pkg::col_t'(1)) begin
      row0_val = fin_prev;
    end else begin
      row0_val = row0;
    end
  end

  always_comb begin
    case (s1.src)
      fsed_pkg::SRC_ZERO: cur_val = '0;
      fsed_pkg::SRC_MEM:  cur_val = rd_data;
      fsed_pkg::SRC_TAIL: cur_val = tail;
      fsed_pkg::SRC_ROW0: cur_val = row0_val;
      default:            cur_val = '0;
    endcase
  end

  assign sum = s1.wrap ? cur_val : (cur_val + e7);

  // finished below-left entries of middle columns go to the line store
  assign wr.en   = retire && (s1.col > fsed_pkg::col_t'(1));
  assign wr.addr = {!s1.bank, s1.col - fsed_pkg::col_t'(1)};
  assign wr.data = fin_prev;

  always_ff @(posedge clk) begin
    if (retire) begin
      res <= fsed_pkg::err_t'(sum[fsed_pkg::ERR_W+3:4]);
      q   <= q_next;
      p0  <= e1;
      if (s1.col == fsed_pkg::col_t'(1) || (s1.wrap && s1.col == '0)) begin
        row0 <= row0_val;
      end
      if (s1.wrap) begin
        tail <= q_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk) disable iff (rst) col <= eff_last)
    else $error("column beyond line end");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (col == '0) && first_line && !bank)
    else $error("width write did not clear position");

  a_wr_col: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (wr.addr[fsed_pkg::COL_W-1:0] != '0))
    else $error("line store write to column zero");

  a_swap: assert property (@(posedge clk) disable iff (rst)
    accept && wrap_now && !cfg_write |=> bank != $past(bank))
    else $error("banks did not swap at line end");
`endif

endmodule
